/* src/tpdp_pkg.sv */
// ----------------------------------------------------------------------------
// tpdp_pkg
// Shared widths, constants and the base-3 digit decode for the ternary
// packed dot product.
// ----------------------------------------------------------------------------
`default_nettype none

package tpdp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ACT_W     = 8;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned ACC_W     = 17;
    localparam int unsigned NUM_TRITS = 5;
    localparam int unsigned TRIT_W    = 2;
    localparam int unsigned POW_W     = 7;
    localparam int unsigned PROD_W    = BYTE_W + POW_W;
    localparam int unsigned TERM_W    = ACT_W + 1;
    // five terms of up to +/-128 each
    localparam int unsigned SUM_W     = TERM_W + 3;

    typedef logic [TRIT_W-1:0]        t_trit;
    typedef logic signed [ACT_W-1:0]  t_act;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_trit TRIT_NEG  = 2'd0;
    localparam t_trit TRIT_ZERO = 2'd1;
    localparam t_trit TRIT_POS  = 2'd2;

    localparam logic [POW_W-1:0] POW3 [NUM_TRITS] = '{7'd1, 7'd3, 7'd9, 7'd27, 7'd81};

    // Digit k of the packed byte: ((byte * 3^k) mod 256) * 3 >> 8.
    function automatic t_trit decode_trit(
        input logic [BYTE_W-1:0] wbyte,
        input logic [2:0]        k
    );
        logic [PROD_W-1:0] prod;
        logic [BYTE_W-1:0] q;
        logic [BYTE_W+1:0] q3;
        prod = PROD_W'(wbyte) * PROD_W'(POW3[k]);
        q    = prod[BYTE_W-1:0];
        q3   = {2'b00, q} + {1'b0, q, 1'b0};
        return q3[BYTE_W+1:BYTE_W];
    endfunction

endpackage

`default_nettype wire

/* src/tpdp_in_if.sv */
// ----------------------------------------------------------------------------
// tpdp_in_if
// Input channel: one packed weight byte, its activations and control bits.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpdp_in_if;
    import tpdp_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   weight_byte;
    t_act                act_zero;
    t_act                act_one;
    t_act                act_two;
    t_act                act_three;
    t_act                act_four;
    logic [COUNT_W-1:0]  trit_count;
    logic                block_end;

    modport source (
        output valid, weight_byte, act_zero, act_one, act_two, act_three, act_four,
               trit_count, block_end,
        input  ready
    );

    modport sink (
        input  valid, weight_byte, act_zero, act_one, act_two, act_three, act_four,
               trit_count, block_end,
        output ready
    );
endinterface

`default_nettype wire

/* src/tpdp_out_if.sv */
// ----------------------------------------------------------------------------
// tpdp_out_if
// Output channel: one signed block sum per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpdp_out_if;
    import tpdp_pkg::*;

    logic valid;
    logic ready;
    t_acc block_dot;

    modport source (
        output valid, block_dot,
        input  ready
    );

    modport sink (
        input  valid, block_dot,
        output ready
    );
endinterface

`default_nettype wire

/* src/ternary_packed_dot_product_top.sv */
// ----------------------------------------------------------------------------
// ternary_packed_dot_product_top
// Base-3 packed ternary weight dot product with per-block integer sums.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per packed weight byte: the byte, the five signed
//   activations its digits pair with, the digit count (5 or 4) and block_end.
//   o_out carries one signed 17-bit block sum per beat marked block_end; the
//   sum includes that beat, and the accumulator restarts at zero after it.
//   Throughput is one input beat per cycle while no block_end beat waits on a
//   stalled result register. A beat is captured in an input register, and
//   the digit decode, five-term add and accumulate run from it into the
//   result register, which drives the block sum on o_out.
//   Reset clears the accumulator and both valid flags.
//   When the receiver stalls, the result register holds its sum. Beats
//   without block_end keep flowing into the accumulator; a block_end beat
//   waits in the input register until the result register frees up, and
//   i_in.ready drops behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_packed_dot_product_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tpdp_in_if.sink     i_in,
    tpdp_out_if.source  o_out
);
    import tpdp_pkg::*;

    // input register
    logic               r_s1_valid;
    logic [BYTE_W-1:0]  r_s1_byte;
    t_act               r_s1_act [NUM_TRITS];
    logic [COUNT_W-1:0] r_s1_count;
    logic               r_s1_end;

    // accumulator and result register
    t_acc               r_acc;
    logic               r_out_valid;
    t_acc               r_out_dot;

    logic               s1_fire;
    logic               in_fire;
    logic signed [SUM_W-1:0] byte_sum;
    t_acc               acc_sum;

    // a block_end beat needs a free result register; other beats never wait
    assign s1_fire  = r_s1_valid && (!r_s1_end || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign in_fire  = i_in.valid && i_in.ready;

    always_comb begin
        logic signed [TERM_W-1:0] a9;
        t_trit                    trit;
        byte_sum = '0;
        for (int k = 0; k < NUM_TRITS; k++) begin
            a9   = {r_s1_act[k][ACT_W-1], r_s1_act[k]};
            trit = decode_trit(r_s1_byte, 3'(k));
            if (r_s1_count > 3'(k)) begin
                unique case (trit)
                    TRIT_NEG: byte_sum = byte_sum - SUM_W'(a9);
                    TRIT_POS: byte_sum = byte_sum + SUM_W'(a9);
                    default:  byte_sum = byte_sum;
                endcase
            end
        end
        acc_sum = r_acc + {{(ACC_W-SUM_W){byte_sum[SUM_W-1]}}, byte_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte   <= i_in.weight_byte;
            r_s1_act[0] <= i_in.act_zero;
            r_s1_act[1] <= i_in.act_one;
            r_s1_act[2] <= i_in.act_two;
            r_s1_act[3] <= i_in.act_three;
            r_s1_act[4] <= i_in.act_four;
            r_s1_count  <= i_in.trit_count;
            r_s1_end    <= i_in.block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_acc <= r_s1_end ? '0 : acc_sum;
            end
            if (s1_fire && r_s1_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_end) begin
            r_out_dot <= acc_sum;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.block_dot = r_out_dot;

endmodule

`default_nettype wire

/* dv/tpdp_block_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpdp_block_checker
// Watches both channels of the ternary dot product, keeps its own running
// block sum from every accepted input beat, and compares each output beat
// against the oldest predicted block sum.
// ----------------------------------------------------------------------------
module tpdp_block_checker
    import tpdp_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    tpdp_in_if           i_in_mon,
    tpdp_out_if          i_out_mon,
    output int unsigned  o_fail_count,
    output int unsigned  o_pending
);

    localparam logic [7:0] DIGIT_SCALE [NUM_TRITS] = '{8'd1, 8'd3, 8'd9, 8'd27, 8'd81};

    t_acc running_sum;
    t_acc expected_sums [$];

    function automatic t_trit base3_digit(input logic [BYTE_W-1:0] wb, input int unsigned k);
        logic [15:0] scaled;
        logic [9:0]  tripled;
        scaled  = 16'(wb) * 16'(DIGIT_SCALE[k]);
        tripled = 10'(scaled[7:0]) * 10'd3;
        return tripled[9:8];
    endfunction

    // Signed contribution of one packed byte; counts above five use all digits.
    function automatic t_acc byte_dot(
        input logic [BYTE_W-1:0]  wb,
        input t_act               acts [NUM_TRITS],
        input logic [COUNT_W-1:0] cnt
    );
        t_acc        sum;
        int unsigned used;
        sum  = '0;
        used = (cnt > NUM_TRITS) ? NUM_TRITS : int'(cnt);
        for (int unsigned k = 0; k < used; k++) begin
            case (base3_digit(wb, k))
                TRIT_POS: sum = sum + t_acc'(acts[k]);
                TRIT_NEG: sum = sum - t_acc'(acts[k]);
                default:  ;
            endcase
        end
        return sum;
    endfunction

    always @(posedge i_clk) begin : watch
        t_act acts [NUM_TRITS];
        t_acc sum_now;
        t_acc want;
        if (!i_rst_n) begin
            running_sum = '0;
            expected_sums.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                acts = '{i_in_mon.act_zero, i_in_mon.act_one, i_in_mon.act_two,
                         i_in_mon.act_three, i_in_mon.act_four};
                sum_now = running_sum + byte_dot(i_in_mon.weight_byte, acts,
                                                 i_in_mon.trit_count);
                if (i_in_mon.block_end) begin
                    expected_sums.push_back(sum_now);
                    running_sum = '0;
                end else begin
                    running_sum = sum_now;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_sums.size() == 0) begin
                    $error("block_dot: no block sum expected, actual %0d",
                           i_out_mon.block_dot);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_sums.pop_front();
                    if (want !== i_out_mon.block_dot) begin
                        $error("block_dot: expected %0d, actual %0d",
                               want, i_out_mon.block_dot);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_sums.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives packed weight bytes and activations into the ternary dot product:
// a directed pass over the extremes and odd digit counts, then random
// blocks with random gaps and output stalls, one long output hold, and a
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
    import tpdp_pkg::*;

    localparam int unsigned TARGET_ITEMS = 1000;
    localparam int unsigned MIN_BLOCKS   = 48;
    localparam int unsigned MAIN_BYTES   = 48;
    localparam int unsigned HIGH_BYTES   = 4;
    localparam int unsigned WRAP_BYTES   = 110;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned HOLD_AFTER   = 10;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic [COUNT_W-1:0] MAIN_COUNT = 3'd5;
    localparam logic [COUNT_W-1:0] HIGH_COUNT = 3'd4;
    localparam logic [39:0]        ALL_MIN    = {5{8'h80}};
    localparam logic [39:0]        ALL_MAX    = {5{8'h7f}};
    localparam logic [39:0]        MIXED      = {8'h7f, 8'h80, 8'h01, 8'hff, 8'h55};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned pending_sums;
    int unsigned items_sent  = 0;
    int unsigned blocks_sent = 0;
    int unsigned idle_cycles = 0;
    bit          send_quiet  = 1'b0;
    bit          take_quiet  = 1'b0;

    tpdp_in_if  in_ch ();
    tpdp_out_if out_ch ();

    ternary_packed_dot_product_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tpdp_block_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_sums)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] rand_act();
        case ($urandom_range(0, 7))
            0:       return 8'h80;
            1:       return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [39:0] rand_acts();
        return {rand_act(), rand_act(), rand_act(), rand_act(), rand_act()};
    endfunction

    task automatic send_beat(
        input logic [BYTE_W-1:0]  wb,
        input logic [39:0]        acts,
        input logic [COUNT_W-1:0] cnt,
        input logic               last
    );
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.weight_byte <= wb;
        in_ch.act_zero    <= acts[7:0];
        in_ch.act_one     <= acts[15:8];
        in_ch.act_two     <= acts[23:16];
        in_ch.act_three   <= acts[31:24];
        in_ch.act_four    <= acts[39:32];
        in_ch.trit_count  <= cnt;
        in_ch.block_end   <= last;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (last) blocks_sent++;
    endtask

    initial begin : stimulus
        int unsigned kind;
        int unsigned len;
        in_ch.valid       <= 1'b0;
        in_ch.weight_byte <= '0;
        in_ch.act_zero    <= '0;
        in_ch.act_one     <= '0;
        in_ch.act_two     <= '0;
        in_ch.act_three   <= '0;
        in_ch.act_four    <= '0;
        in_ch.trit_count  <= '0;
        in_ch.block_end   <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of byte and activations, one-beat blocks
        send_beat(8'd0,   ALL_MIN, MAIN_COUNT, 1'b1);
        send_beat(8'd242, ALL_MAX, MAIN_COUNT, 1'b1);
        send_beat(8'd255, ALL_MIN, MAIN_COUNT, 1'b1);
        // high byte: fifth activation must not count
        send_beat(8'd255, ALL_MAX, HIGH_COUNT, 1'b1);
        send_beat(8'd121, MIXED,   HIGH_COUNT, 1'b0);
        send_beat(8'd121, MIXED,   MAIN_COUNT, 1'b1);
        // zero digits, then counts above five
        send_beat(8'd0,   ALL_MIN, 3'd0, 1'b1);
        send_beat(8'd1,   ALL_MAX, 3'd6, 1'b0);
        send_beat(8'd200, ALL_MIN, 3'd7, 1'b1);
        // short counts
        send_beat(8'd81,  MIXED,   3'd1, 1'b0);
        send_beat(8'd27,  MIXED,   3'd2, 1'b0);
        send_beat(8'd9,   MIXED,   3'd3, 1'b1);
        send_beat(8'd3,   ALL_MAX, MAIN_COUNT, 1'b0);
        send_beat(8'd1,   ALL_MIN, MAIN_COUNT, 1'b1);
        for (int unsigned i = 0; i < 4; i++)
            send_beat(8'($urandom), rand_acts(), MAIN_COUNT, i == 3);

        // long block of maximal positive terms, wraps the 17-bit sum
        for (int unsigned i = 0; i < WRAP_BYTES; i++)
            send_beat(8'd0, ALL_MIN, MAIN_COUNT, i == WRAP_BYTES - 1);

        while (items_sent < TARGET_ITEMS || blocks_sent < MIN_BLOCKS) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                len = $urandom_range(1, 8);
                for (int unsigned i = 0; i < len; i++)
                    send_beat(8'($urandom), rand_acts(),
                              ($urandom_range(0, 2) == 0) ? HIGH_COUNT : MAIN_COUNT,
                              i == len - 1);
            end else if (kind < 15) begin
                // full block: main bytes of five digits, then the high bytes
                for (int unsigned i = 0; i < MAIN_BYTES + HIGH_BYTES; i++)
                    send_beat(8'($urandom), rand_acts(),
                              (i < MAIN_BYTES) ? MAIN_COUNT : HIGH_COUNT,
                              i == MAIN_BYTES + HIGH_BYTES - 1);
            end else begin
                len = $urandom_range(1, 6);
                for (int unsigned i = 0; i < len; i++)
                    send_beat(8'($urandom), rand_acts(), COUNT_W'($urandom_range(0, 7)),
                              $urandom_range(0, 2) == 0);
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_sums != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : receiver
        int unsigned stall;
        int unsigned taken;
        bit          held;
        taken = 0;
        held  = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // long hold: let the result register fill and back up the input
            if (!held && taken == HOLD_AFTER) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 15) == 0) take_quiet = !take_quiet;
            stall = take_quiet ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
